// ===== sv/cmam_pkg.sv =====
// Shared types and codes for the CPU memory with 6502 address modes.
package cmam_pkg;

  // Command codes carried by one input word.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_ADDR  = 2'd2
  } cmd_e;

  // 6502 addressing modes; codes 13 to 15 are undefined.
  typedef enum logic [3:0] {
    MODE_IMP = 4'd0,
    MODE_ACC = 4'd1,
    MODE_IMM = 4'd2,
    MODE_ZP  = 4'd3,
    MODE_ZPX = 4'd4,
    MODE_ZPY = 4'd5,
    MODE_REL = 4'd6,
    MODE_ABS = 4'd7,
    MODE_ABX = 4'd8,
    MODE_ABY = 4'd9,
    MODE_IND = 4'd10,
    MODE_INX = 4'd11,
    MODE_INY = 4'd12
  } mode_e;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MAP   = 5'b00100,
    S_ACC   = 5'b01000,
    S_DATA  = 5'b10000
  } state_e;

  // Fetch steps of an address calculation.
  localparam logic [1:0] STEP_OPER_LO = 2'd0;
  localparam logic [1:0] STEP_OPER_HI = 2'd1;
  localparam logic [1:0] STEP_PTR_LO  = 2'd2;
  localparam logic [1:0] STEP_PTR_HI  = 2'd3;

endpackage

// ===== sv/cpu_memory_with_address_modes_unit.sv =====
// Byte memory with read, write and 6502 effective address calculation.
// For a power-of-two MEM_BYTES each memory access is a registered address step and then a data
// step; modes without fetch need no access, a write, a read or a zero page mode one, absolute two,
// (zp,X) and (zp),Y three, (abs) four; another size adds an address reduction step per access.
// busy drops as done_o rises, so a new word is taken only once the last is done; results show one cycle.
// After reset a clearing pass zeroes every memory byte with busy high.
module cpu_memory_with_address_modes_unit #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           command_i,
  input  logic [15:0]          address_i,
  input  logic [7:0]           write_data_i,
  input  logic [3:0]           mode_i,
  input  logic [15:0]          program_counter_i,
  input  logic [7:0]           index_x_i,
  input  logic [7:0]           index_y_i,
  output logic                 done_o,
  output logic [7:0]           read_data_o,
  output logic [15:0]          effective_address_o,
  output logic                 mode_error_o
);
  import cmam_pkg::*;

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam bit POW2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);
  localparam logic [24:0] Recip = 25'(((64'd1 << 32) + 64'(MEM_BYTES) - 64'd1) / MEM_BYTES);
  localparam logic [16:0] MemSize = 17'(MEM_BYTES);
  localparam logic [AW-1:0] LastIdx = AW'(MEM_BYTES - 1);

  state_e      state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  cmd_e        cmd_q, cmd_d;
  mode_e       mode_q, mode_d;
  logic [7:0]  x_q, x_d, y_q, y_d, wdata_q, wdata_d, lo_q, lo_d;
  logic [1:0]  step_q, step_d;
  logic [15:0] ptr_q, ptr_d, raw_q, raw_d;
  logic [40:0] prod_q;

  logic        done_q, done_d;
  logic [7:0]  rd_q, rd_d;
  logic [15:0] ea_q, ea_d;
  logic        err_q, err_d;

  logic [7:0]  mem_q [MEM_BYTES];
  logic [7:0]  rdata_q;
  logic [AW-1:0] mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wdata;

  logic [8:0]  quot;
  logic [16:0] qm, rem, rem_c;
  logic [AW-1:0] map_idx;
  logic [15:0] pc_next, word;
  logic [7:0]  sum_b;
  state_e      acc_state;

  // Address reduction modulo MEM_BYTES; a mask when the size is a power of two.
  assign quot    = prod_q[40:32];
  assign qm      = 17'(quot * MemSize);
  assign rem     = {1'b0, raw_q} - qm;
  assign rem_c   = (rem >= MemSize) ? rem - MemSize : rem;
  assign map_idx = POW2 ? raw_q[AW-1:0] : rem_c[AW-1:0];
  assign acc_state = POW2 ? S_ACC : S_MAP;

  assign pc_next = program_counter_i + 16'd1;
  assign word    = {rdata_q, lo_q};
  assign sum_b   = rdata_q + ((mode_q == MODE_ZPY) ? y_q : x_q);

  // Memory port control.
  always_comb begin
    mem_addr  = map_idx;
    mem_we    = 1'b0;
    mem_wdata = wdata_q;
    case (state_q)
      S_CLEAR: begin
        mem_addr  = clr_q;
        mem_we    = 1'b1;
        mem_wdata = 8'h00;
      end
      S_ACC: begin
        mem_we = (cmd_q == CMD_WRITE);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_d   = cmd_q;
    mode_d  = mode_q;
    x_d     = x_q;
    y_d     = y_q;
    wdata_d = wdata_q;
    lo_d    = lo_q;
    step_d  = step_q;
    ptr_d   = ptr_q;
    raw_d   = raw_q;
    done_d  = 1'b0;
    rd_d    = 8'h00;
    ea_d    = 16'h0000;
    err_d   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_d   = cmd_e'(command_i);
          mode_d  = mode_e'(mode_i);
          x_d     = index_x_i;
          y_d     = index_y_i;
          wdata_d = write_data_i;
          step_d  = STEP_OPER_LO;
          case (command_i)
            CMD_WRITE, CMD_READ: begin
              raw_d   = address_i;
              state_d = acc_state;
            end
            CMD_ADDR: begin
              raw_d = pc_next;
              case (mode_i) inside
                MODE_IMP, MODE_ACC: begin
                  done_d = 1'b1;
                end
                MODE_IMM, MODE_REL: begin
                  done_d = 1'b1;
                  ea_d   = pc_next;
                end
                [MODE_ZP:MODE_ZPY], [MODE_ABS:MODE_INY]: begin
                  state_d = acc_state;
                end
                default: begin
                  done_d = 1'b1;
                  err_d  = 1'b1;
                end
              endcase
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_MAP: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (cmd_q == CMD_WRITE) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_DATA;
        end
      end
      S_DATA: begin
        state_d = acc_state;
        if (cmd_q == CMD_READ) begin
          done_d  = 1'b1;
          rd_d    = rdata_q;
          state_d = S_IDLE;
        end else begin
          case (step_q)
            STEP_OPER_LO: begin
              case (mode_q) inside
                MODE_ZP: begin
                  done_d  = 1'b1;
                  ea_d    = {8'h00, rdata_q};
                  state_d = S_IDLE;
                end
                MODE_ZPX, MODE_ZPY: begin
                  done_d  = 1'b1;
                  ea_d    = {8'h00, sum_b};
                  state_d = S_IDLE;
                end
                MODE_INX: begin
                  ptr_d  = {8'h00, sum_b};
                  raw_d  = {8'h00, sum_b};
                  step_d = STEP_PTR_LO;
                end
                MODE_INY: begin
                  ptr_d  = {8'h00, rdata_q};
                  raw_d  = {8'h00, rdata_q};
                  step_d = STEP_PTR_LO;
                end
                default: begin
                  // Absolute, absolute indexed and absolute indirect: fetch the operand's high byte.
                  lo_d   = rdata_q;
                  raw_d  = raw_q + 16'd1;
                  step_d = STEP_OPER_HI;
                end
              endcase
            end
            STEP_OPER_HI: begin
              case (mode_q)
                MODE_IND: begin
                  ptr_d  = word;
                  raw_d  = word;
                  step_d = STEP_PTR_LO;
                end
                MODE_ABX: begin
                  done_d  = 1'b1;
                  ea_d    = word + {8'h00, x_q};
                  state_d = S_IDLE;
                end
                MODE_ABY: begin
                  done_d  = 1'b1;
                  ea_d    = word + {8'h00, y_q};
                  state_d = S_IDLE;
                end
                default: begin
                  done_d  = 1'b1;
                  ea_d    = word;
                  state_d = S_IDLE;
                end
              endcase
            end
            STEP_PTR_LO: begin
              lo_d   = rdata_q;
              step_d = STEP_PTR_HI;
              if (mode_q == MODE_IND) begin
                raw_d = ptr_q + 16'd1;
              end else begin
                // Zero page pointers wrap within page zero.
                raw_d = {8'h00, ptr_q[7:0] + 8'd1};
              end
            end
            default: begin
              done_d  = 1'b1;
              state_d = S_IDLE;
              if (mode_q == MODE_INY) begin
                ea_d = word + {8'h00, y_q};
              end else begin
                ea_d = word;
              end
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    mode_q  <= mode_d;
    x_q     <= x_d;
    y_q     <= y_d;
    wdata_q <= wdata_d;
    lo_q    <= lo_d;
    step_q  <= step_d;
    ptr_q   <= ptr_d;
    raw_q   <= raw_d;
    prod_q  <= 41'(raw_q) * 41'(Recip);
    rd_q    <= rd_d;
    ea_q    <= ea_d;
    err_q   <= err_d;
  end

  // Single-port byte memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  assign busy                = (state_q != S_IDLE);
  assign done_o              = done_q;
  assign read_data_o         = rd_q;
  assign effective_address_o = ea_q;
  assign mode_error_o        = err_q;

endmodule
